// File: src/dpid_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dpid_pkg
// Types and constants of the drive PID / heading hold controller.
// ----------------------------------------------------------------------------
package dpid_pkg;

  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DATA_W = 16;

  // output saturation and fixed codes
  localparam logic signed [10:0] DRIVE_MAX = 11'sd254;
  localparam logic [6:0] CATAPULT_RELOAD = 7'd127;
  localparam logic [6:0] CATAPULT_OFF = 7'd0;
  localparam logic [15:0] DEG_TO_CDEG = 16'd100;
  localparam logic [9:0] COUNT_MAX = 10'd1023;

  localparam logic [0:0] OP_START = 1'b0;
  localparam logic [0:0] OP_SAMPLE = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DIST_KP        = 3'd0,
    REG_DIST_KI        = 3'd1,
    REG_DIST_KD        = 3'd2,
    REG_TURN_KP        = 3'd3,
    REG_TICKS_PER_INCH = 3'd4,
    REG_DIST_TOL       = 3'd5,
    REG_TURN_TOL       = 3'd6,
    REG_TIMEOUT        = 3'd7
  } cfg_reg_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_TGT_MUL,
    ST_TGT_SAVE,
    ST_HDG_SAVE,
    ST_ERR,
    ST_MUL_P,
    ST_MUL_D,
    ST_MUL_IL,
    ST_MUL_IH,
    ST_MUL_TURN,
    ST_MIX,
    ST_EMIT,
    ST_STOP
  } state_t;

endpackage

// File: src/drive_pid_with_heading_hold_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// drive_pid_with_heading_hold_core
// Differential drive move controller: distance PID with heading hold.
// ----------------------------------------------------------------------------
// A start item latches a move, works through the target multiply and save
// states and gives no result. A sample item during a move works through the
// error, multiply and mix states, then places its drive result and, when the
// move ends, the stop result; each waits while the output register is still
// held. All products (target ticks, heading target, P, D, the two halves of
// the integral term, heading P) go in turn through one 22x17 signed
// multiplier with a registered product. in_stall is high while an item is
// being worked on. Configuration writes are always taken (cfg_ready is high).
// ----------------------------------------------------------------------------
module drive_pid_with_heading_hold_core
  import dpid_pkg::*;
#(
  parameter int unsigned TURN_LIMIT = 127
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic                     in_opcode,
  input  logic signed [10:0]       in_move_inches,
  input  logic signed [11:0]       in_move_degrees,
  input  logic [6:0]               in_speed_cap,
  input  logic signed [17:0]       in_encoder_avg,
  input  logic signed [20:0]       in_heading_now,
  input  logic                     in_limit_switch,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic signed [8:0]        out_left_drive,
  output logic signed [8:0]        out_right_drive,
  output logic [6:0]               out_catapult_drive,
  output logic                     out_move_done,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [CFG_IDX_W-1:0]     cfg_index,
  input  logic [CFG_DATA_W-1:0]    cfg_data
);

  localparam logic signed [30:0] TGT_MAX = 31'sd131071;
  localparam logic signed [30:0] TGT_MIN = -31'sd131072;
  localparam logic signed [22:0] ROT_MAX = 23'(TURN_LIMIT);
  localparam logic signed [22:0] ROT_MIN = -23'(TURN_LIMIT);

  // configuration
  logic [15:0] kp_r, ki_r, kd_r, tkp_r, tpi_r;
  logic [11:0] dtol_r, ttol_r;
  logic [9:0]  tmo_r;

  state_t state_r, state_nxt;
  logic   active_r, active_nxt;
  logic   out_valid_r, out_valid_nxt;

  // latched item
  logic signed [10:0] inches_r;
  logic signed [11:0] deg_r;
  logic [6:0]         cap_r;
  logic signed [17:0] enc_r;
  logic signed [20:0] head_r;
  logic               lim_r;

  // move state
  logic signed [17:0] tgt_ticks_r, tgt_ticks_nxt;
  logic signed [20:0] tgt_head_r, tgt_head_nxt;
  logic signed [18:0] prev_err_r, prev_err_nxt;
  logic signed [39:0] sum_r, sum_nxt;
  logic [9:0]         count_r, count_nxt;

  // step registers
  logic signed [18:0] err_r, err_nxt;
  logic signed [19:0] deriv_r, deriv_nxt;
  logic signed [21:0] rerr_r, rerr_nxt;
  logic signed [38:0] prod_r;
  logic signed [59:0] acc_r, acc_nxt;
  logic signed [8:0]  left_r, left_nxt, right_r, right_nxt;
  logic               done_r, done_nxt;

  logic signed [8:0]  out_left_r, out_left_nxt, out_right_r, out_right_nxt;
  logic [6:0]         out_cata_r, out_cata_nxt;
  logic               out_done_r, out_done_nxt;

  // shared multiplier
  logic signed [21:0] mul_a;
  logic [15:0]        mul_b;
  logic signed [38:0] mul_p;

  logic in_xfer, slot_free;

  logic signed [30:0] tgt_sh;
  logic signed [18:0] err_c;
  logic signed [40:0] sum_add;
  logic signed [39:0] sum_sat;
  logic signed [59:0] acc_term;
  logic signed [51:0] trans_sh, cap_pos, cap_neg;
  logic signed [7:0]  transform;
  logic signed [22:0] rot_sh;
  logic signed [8:0]  rotate;
  logic signed [10:0] mix_l, mix_r;
  logic [18:0]        err_abs;
  logic [21:0]        rerr_abs;
  logic [9:0]         count_inc;

  assign cfg_ready = 1'b1;
  assign in_stall = (state_r != ST_IDLE);
  assign in_xfer = in_valid && !in_stall;
  assign slot_free = !out_valid_r || !out_stall;

  assign out_valid = out_valid_r;
  assign out_left_drive = out_left_r;
  assign out_right_drive = out_right_r;
  assign out_catapult_drive = out_cata_r;
  assign out_move_done = out_done_r;

  assign mul_p = mul_a * $signed({1'b0, mul_b});

  always_comb begin
    state_nxt = state_r;
    active_nxt = active_r;
    out_valid_nxt = out_valid_r && out_stall;
    tgt_ticks_nxt = tgt_ticks_r;
    tgt_head_nxt = tgt_head_r;
    prev_err_nxt = prev_err_r;
    sum_nxt = sum_r;
    count_nxt = count_r;
    err_nxt = err_r;
    deriv_nxt = deriv_r;
    rerr_nxt = rerr_r;
    acc_nxt = acc_r;
    left_nxt = left_r;
    right_nxt = right_r;
    done_nxt = done_r;
    out_left_nxt = out_left_r;
    out_right_nxt = out_right_r;
    out_cata_nxt = out_cata_r;
    out_done_nxt = out_done_r;
    mul_a = '0;
    mul_b = '0;

    tgt_sh = 31'(prod_r >>> 8);
    err_c = $signed({tgt_ticks_r[17], tgt_ticks_r}) - $signed({enc_r[17], enc_r});
    sum_add = $signed({sum_r[39], sum_r}) + $signed({{22{err_c[18]}}, err_c});
    if (sum_add[40] != sum_add[39]) begin
      sum_sat = sum_add[40] ? {1'b1, 39'd0} : {1'b0, {39{1'b1}}};
    end else begin
      sum_sat = sum_add[39:0];
    end
    acc_term = (state_r == ST_MUL_TURN) ? ($signed({{21{prod_r[38]}}, prod_r}) <<< 20)
                                        : $signed({{21{prod_r[38]}}, prod_r});

    trans_sh = 52'(acc_r >>> 8);
    cap_pos = $signed({45'd0, cap_r});
    cap_neg = -cap_pos;
    if (trans_sh > cap_pos) begin
      transform = 8'(cap_pos);
    end else if (trans_sh < cap_neg) begin
      transform = 8'(cap_neg);
    end else begin
      transform = trans_sh[7:0];
    end
    rot_sh = 23'(prod_r >>> 16);
    if (rot_sh > ROT_MAX) begin
      rotate = 9'(ROT_MAX);
    end else if (rot_sh < ROT_MIN) begin
      rotate = 9'(ROT_MIN);
    end else begin
      rotate = rot_sh[8:0];
    end
    if (inches_r == '0) begin
      mix_l = 11'(rotate);
      mix_r = -11'(rotate);
    end else begin
      mix_l = 11'(transform) + 11'(rotate);
      mix_r = 11'(transform) - 11'(rotate);
    end
    err_abs = err_r[18] ? 19'(-err_r) : 19'(err_r);
    rerr_abs = rerr_r[21] ? 22'(-rerr_r) : 22'(rerr_r);
    count_inc = (count_r == COUNT_MAX) ? count_r : count_r + 10'd1;

    unique case (state_r)
      ST_IDLE: begin
        if (in_xfer) begin
          if (in_opcode == OP_START) begin
            active_nxt = 1'b1;
            prev_err_nxt = '0;
            sum_nxt = '0;
            count_nxt = '0;
            state_nxt = ST_TGT_MUL;
          end else if (active_r) begin
            state_nxt = ST_ERR;
          end
        end
      end
      ST_TGT_MUL: begin
        mul_a = 22'(inches_r);
        mul_b = tpi_r;
        state_nxt = ST_TGT_SAVE;
      end
      ST_TGT_SAVE: begin
        if (tgt_sh > TGT_MAX) begin
          tgt_ticks_nxt = 18'(TGT_MAX);
        end else if (tgt_sh < TGT_MIN) begin
          tgt_ticks_nxt = 18'(TGT_MIN);
        end else begin
          tgt_ticks_nxt = tgt_sh[17:0];
        end
        mul_a = 22'(deg_r);
        mul_b = DEG_TO_CDEG;
        state_nxt = ST_HDG_SAVE;
      end
      ST_HDG_SAVE: begin
        tgt_head_nxt = prod_r[20:0];
        state_nxt = ST_IDLE;
      end
      ST_ERR: begin
        err_nxt = err_c;
        deriv_nxt = $signed({err_c[18], err_c}) - $signed({prev_err_r[18], prev_err_r});
        rerr_nxt = $signed({tgt_head_r[20], tgt_head_r}) - $signed({head_r[20], head_r});
        // integral resets on zero error or error beyond the inch count
        if (err_c == '0 || err_c > $signed({{8{inches_r[10]}}, inches_r})) begin
          sum_nxt = '0;
        end else begin
          sum_nxt = sum_sat;
        end
        state_nxt = ST_MUL_P;
      end
      ST_MUL_P: begin
        acc_nxt = '0;
        mul_a = 22'(err_r);
        mul_b = kp_r;
        state_nxt = ST_MUL_D;
      end
      ST_MUL_D: begin
        acc_nxt = acc_r + acc_term;
        mul_a = 22'(deriv_r);
        mul_b = kd_r;
        state_nxt = ST_MUL_IL;
      end
      ST_MUL_IL: begin
        acc_nxt = acc_r + acc_term;
        mul_a = $signed({2'b00, sum_r[19:0]});
        mul_b = ki_r;
        state_nxt = ST_MUL_IH;
      end
      ST_MUL_IH: begin
        acc_nxt = acc_r + acc_term;
        mul_a = 22'($signed(sum_r[39:20]));
        mul_b = ki_r;
        state_nxt = ST_MUL_TURN;
      end
      ST_MUL_TURN: begin
        // upper integral half weighs 2^20
        acc_nxt = acc_r + acc_term;
        mul_a = rerr_r;
        mul_b = tkp_r;
        state_nxt = ST_MIX;
      end
      ST_MIX: begin
        if (mix_l > DRIVE_MAX) begin
          left_nxt = 9'(DRIVE_MAX);
        end else if (mix_l < -DRIVE_MAX) begin
          left_nxt = 9'(-DRIVE_MAX);
        end else begin
          left_nxt = mix_l[8:0];
        end
        if (mix_r > DRIVE_MAX) begin
          right_nxt = 9'(DRIVE_MAX);
        end else if (mix_r < -DRIVE_MAX) begin
          right_nxt = 9'(-DRIVE_MAX);
        end else begin
          right_nxt = mix_r[8:0];
        end
        prev_err_nxt = err_r;
        count_nxt = count_inc;
        done_nxt = (err_abs <= {7'd0, dtol_r} && rerr_abs <= {10'd0, ttol_r})
                   || (count_inc >= tmo_r);
        if (done_nxt) begin
          active_nxt = 1'b0;
        end
        state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_left_nxt = left_r;
          out_right_nxt = right_r;
          out_cata_nxt = lim_r ? CATAPULT_OFF : CATAPULT_RELOAD;
          out_done_nxt = 1'b0;
          state_nxt = done_r ? ST_STOP : ST_IDLE;
        end
      end
      ST_STOP: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_left_nxt = '0;
          out_right_nxt = '0;
          out_cata_nxt = CATAPULT_OFF;
          out_done_nxt = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      active_r <= 1'b0;
      out_valid_r <= 1'b0;
      kp_r <= 16'd77;
      ki_r <= 16'd0;
      kd_r <= 16'd256;
      tkp_r <= 16'd1311;
      tpi_r <= 16'd3226;
      dtol_r <= 12'd13;
      ttol_r <= 12'd100;
      tmo_r <= 10'd325;
    end else begin
      state_r <= state_nxt;
      active_r <= active_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_reg_t'(cfg_index))
          REG_DIST_KP:        kp_r <= cfg_data;
          REG_DIST_KI:        ki_r <= cfg_data;
          REG_DIST_KD:        kd_r <= cfg_data;
          REG_TURN_KP:        tkp_r <= cfg_data;
          REG_TICKS_PER_INCH: tpi_r <= cfg_data;
          REG_DIST_TOL:       dtol_r <= cfg_data[11:0];
          REG_TURN_TOL:       ttol_r <= cfg_data[11:0];
          REG_TIMEOUT:        tmo_r <= cfg_data[9:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      if (in_opcode == OP_START) begin
        inches_r <= in_move_inches;
        deg_r <= in_move_degrees;
        cap_r <= in_speed_cap;
      end else begin
        enc_r <= in_encoder_avg;
        head_r <= in_heading_now;
        lim_r <= in_limit_switch;
      end
    end
    tgt_ticks_r <= tgt_ticks_nxt;
    tgt_head_r <= tgt_head_nxt;
    prev_err_r <= prev_err_nxt;
    sum_r <= sum_nxt;
    count_r <= count_nxt;
    err_r <= err_nxt;
    deriv_r <= deriv_nxt;
    rerr_r <= rerr_nxt;
    prod_r <= mul_p;
    acc_r <= acc_nxt;
    left_r <= left_nxt;
    right_r <= right_nxt;
    done_r <= done_nxt;
    out_left_r <= out_left_nxt;
    out_right_r <= out_right_nxt;
    out_cata_r <= out_cata_nxt;
    out_done_r <= out_done_nxt;
  end

endmodule

// File: dv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the drive PID / heading hold core. A predictor
// that runs beside the core works out the drive commands of every accepted
// item, and a checker compares each result transfer against them in order.
// Directed moves cover pure turns, saturated targets, timeouts and the
// integral clear rules; random moves track the target so that they settle.
// ----------------------------------------------------------------------------
module tb;
  import dpid_pkg::*;

  localparam int TURN_LIMIT = 127;
  localparam int ITEM_TARGET = 1550;
  localparam int SETTLE_CYCLES = 24;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam longint SUM_MAX = (longint'(1) <<< 39) - 1;

  typedef struct {
    logic [0:0]          opcode;
    logic signed [10:0]  inches;
    logic signed [11:0]  degrees;
    logic [6:0]          cap;
    logic signed [17:0]  enc;
    logic signed [20:0]  head;
    logic                lsw;
  } move_item_t;

  typedef struct {
    logic signed [8:0] left;
    logic signed [8:0] right;
    logic [6:0]        cata;
    logic              done;
  } drive_cmd_t;

  logic clk;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic in_opcode = 1'b0;
  logic signed [10:0] in_move_inches = '0;
  logic signed [11:0] in_move_degrees = '0;
  logic [6:0] in_speed_cap = '0;
  logic signed [17:0] in_encoder_avg = '0;
  logic signed [20:0] in_heading_now = '0;
  logic in_limit_switch = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [8:0] out_left_drive;
  logic signed [8:0] out_right_drive;
  logic [6:0] out_catapult_drive;
  logic out_move_done;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  drive_pid_with_heading_hold_core #(
    .TURN_LIMIT(TURN_LIMIT)
  ) dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_opcode(in_opcode),
    .in_move_inches(in_move_inches),
    .in_move_degrees(in_move_degrees),
    .in_speed_cap(in_speed_cap),
    .in_encoder_avg(in_encoder_avg),
    .in_heading_now(in_heading_now),
    .in_limit_switch(in_limit_switch),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_left_drive(out_left_drive),
    .out_right_drive(out_right_drive),
    .out_catapult_drive(out_catapult_drive),
    .out_move_done(out_move_done),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // shadow configuration, reset values
  logic [15:0] k_dist_p = 16'd77;
  logic [15:0] k_dist_i = 16'd0;
  logic [15:0] k_dist_d = 16'd256;
  logic [15:0] k_turn_p = 16'd1311;
  logic [15:0] k_tpi = 16'd3226;
  logic [11:0] tol_dist = 12'd13;
  logic [11:0] tol_turn = 12'd100;
  logic [9:0]  timeout = 10'd325;

  // shadow move state
  bit     pm_active = 1'b0;
  longint pm_target_ticks = 0;
  longint pm_target_hdg = 0;
  longint pm_inches = 0;
  longint pm_cap = 0;
  longint pm_prev_err = 0;
  longint pm_err_sum = 0;
  longint pm_count = 0;

  drive_cmd_t pending_cmds[$];
  int n_errors = 0;
  int work_items = 0;
  int tx_burst = 0;
  bit tx_no_gap = 1'b0;
  int rx_hold = 0;
  int quiet_cycles = 0;

  function automatic longint clip(longint v, longint lo, longint hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  function automatic longint mag(longint v);
    return (v < 0) ? -v : v;
  endfunction

  task automatic predict_drive(input move_item_t it);
    longint err, deriv, acc, xform, rerr, rot, l, r;
    drive_cmd_t c;
    if (it.opcode == OP_START) begin
      pm_inches = longint'(it.inches);
      pm_target_ticks = clip((pm_inches * longint'(k_tpi)) >>> 8, -131072, 131071);
      pm_target_hdg = longint'(it.degrees) * 100;
      pm_cap = longint'(it.cap);
      pm_prev_err = 0;
      pm_err_sum = 0;
      pm_count = 0;
      pm_active = 1'b1;
      return;
    end
    if (!pm_active) return;
    err = pm_target_ticks - longint'(it.enc);
    deriv = err - pm_prev_err;
    pm_err_sum = clip(pm_err_sum + err, -SUM_MAX - 1, SUM_MAX);
    if (err == 0 || err > pm_inches) pm_err_sum = 0;
    acc = err * longint'(k_dist_p) + deriv * longint'(k_dist_d)
        + pm_err_sum * longint'(k_dist_i);
    xform = clip(acc >>> 8, -pm_cap, pm_cap);
    rerr = pm_target_hdg - longint'(it.head);
    rot = clip((rerr * longint'(k_turn_p)) >>> 16, -TURN_LIMIT, TURN_LIMIT);
    if (pm_inches == 0) begin
      l = rot;
      r = -rot;
    end else begin
      l = xform + rot;
      r = xform - rot;
    end
    l = clip(l, -longint'(DRIVE_MAX), longint'(DRIVE_MAX));
    r = clip(r, -longint'(DRIVE_MAX), longint'(DRIVE_MAX));
    c.left = l[8:0];
    c.right = r[8:0];
    c.cata = it.lsw ? CATAPULT_OFF : CATAPULT_RELOAD;
    c.done = 1'b0;
    pending_cmds.push_back(c);
    pm_prev_err = err;
    if (pm_count < longint'(COUNT_MAX)) pm_count++;
    if ((mag(err) <= longint'(tol_dist) && mag(rerr) <= longint'(tol_turn)) ||
        pm_count >= longint'(timeout)) begin
      pm_active = 1'b0;
      c.left = '0;
      c.right = '0;
      c.cata = CATAPULT_OFF;
      c.done = 1'b1;
      pending_cmds.push_back(c);
    end
  endtask

  function automatic int tx_gap();
    int r;
    if (tx_no_gap) return 0;
    if (tx_burst > 0) begin
      tx_burst--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 2) begin
      tx_burst = $urandom_range(20, 80);
      return 0;
    end
    if (r < 45) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 50);
  endfunction

  task automatic send_item(input move_item_t it);
    int gap;
    in_valid <= 1'b1;
    in_opcode <= it.opcode;
    in_move_inches <= it.inches;
    in_move_degrees <= it.degrees;
    in_speed_cap <= it.cap;
    in_encoder_avg <= it.enc;
    in_heading_now <= it.head;
    in_limit_switch <= it.lsw;
    forever begin
      @(posedge clk);
      if (!in_stall) break;
    end
    if (it.opcode == OP_START || pm_active) work_items++;
    predict_drive(it);
    gap = tx_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic release_input();
    in_valid <= 1'b0;
  endtask

  // core idle: every result in, then time for a start that gives none
  task automatic drain_block();
    release_input();
    while (pending_cmds.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_cfg(input cfg_reg_t idx, input logic [15:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    forever begin
      @(posedge clk);
      if (cfg_ready) break;
    end
    case (idx)
      REG_DIST_KP:        k_dist_p = data;
      REG_DIST_KI:        k_dist_i = data;
      REG_DIST_KD:        k_dist_d = data;
      REG_TURN_KP:        k_turn_p = data;
      REG_TICKS_PER_INCH: k_tpi = data;
      REG_DIST_TOL:       tol_dist = data[11:0];
      REG_TURN_TOL:       tol_turn = data[11:0];
      REG_TIMEOUT:        timeout = data[9:0];
      default: ;
    endcase
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  function automatic move_item_t mk_item(logic op, int inches, int deg, int cap,
                                         int enc, int head, logic lsw);
    move_item_t it;
    it.opcode = op;
    it.inches = inches[10:0];
    it.degrees = deg[11:0];
    it.cap = cap[6:0];
    it.enc = enc[17:0];
    it.head = head[20:0];
    it.lsw = lsw;
    return it;
  endfunction

  function automatic move_item_t rand_item();
    move_item_t it;
    it.opcode = 1'($urandom_range(0, 1));
    it.inches = 11'($urandom);
    it.degrees = 12'($urandom_range(0, 2160) - 1080);
    it.cap = 7'($urandom);
    it.enc = 18'($urandom);
    it.head = 21'($urandom);
    it.lsw = 1'($urandom);
    return it;
  endfunction

  function automatic move_item_t random_start();
    move_item_t it;
    it = rand_item();
    it.opcode = OP_START;
    if ($urandom_range(0, 9) != 0) it.inches = 11'($urandom_range(0, 80) - 40);
    if ($urandom_range(0, 9) != 0) it.degrees = 12'($urandom_range(0, 40) - 20);
    return it;
  endfunction

  // offset from the target: near the tolerance edge, within a wider span, or fully random
  function automatic longint pick_offset(longint tol, int span);
    int r;
    r = $urandom_range(0, 9);
    if (r < 4) return longint'($urandom_range(0, 32'(2 * tol + 2))) - tol - 1;
    if (r < 9) return longint'($urandom_range(0, 2 * span)) - span;
    return longint'($signed($urandom));
  endfunction

  function automatic move_item_t track_item();
    move_item_t it;
    longint v;
    it = rand_item();
    it.opcode = OP_SAMPLE;
    v = clip(pm_target_ticks - pick_offset(longint'(tol_dist), 3000), -131072, 131071);
    it.enc = v[17:0];
    v = clip(pm_target_hdg - pick_offset(longint'(tol_turn), 20000), -1048576, 1048575);
    it.head = v[20:0];
    return it;
  endfunction

  function automatic logic [15:0] cfg_value(input cfg_reg_t idx);
    int r;
    r = $urandom_range(0, 5);
    if (r == 0) return 16'h0000;
    if (r == 1) return 16'hFFFF;
    case (idx)
      REG_DIST_KP:        return 16'($urandom_range(0, 600));
      REG_DIST_KI:        return 16'($urandom_range(0, 40));
      REG_DIST_KD:        return 16'($urandom_range(0, 1024));
      REG_TURN_KP:        return 16'($urandom_range(0, 5000));
      REG_TICKS_PER_INCH: return 16'($urandom_range(0, 4000));
      REG_DIST_TOL:       return {4'($urandom), 12'($urandom_range(0, 100))};
      REG_TURN_TOL:       return {4'($urandom), 12'($urandom_range(0, 300))};
      default:            return {6'($urandom), 10'($urandom_range(0, 60))};
    endcase
  endfunction

  task automatic randomize_config();
    for (int i = 0; i < 8; i++) begin
      if ($urandom_range(0, 2) != 0) write_cfg(cfg_reg_t'(i), cfg_value(cfg_reg_t'(i)));
    end
  endtask

  task automatic random_move();
    move_item_t it;
    int n;
    send_item(random_start());
    n = $urandom_range(1, 30);
    for (int k = 0; k < n && pm_active; k++) begin
      if ($urandom_range(0, 15) == 0) send_item(rand_item());
      else send_item(track_item());
    end
    // a sample with no move in progress is dropped
    if (!pm_active && $urandom_range(0, 7) == 0) begin
      it = rand_item();
      it.opcode = OP_SAMPLE;
      send_item(it);
    end
  endtask

  task automatic test_idle_and_turn();
    send_item(mk_item(OP_SAMPLE, -1, -1, 127, -1, -1, 1'b1));
    send_item(mk_item(OP_START, 0, 90, 127, 0, 0, 1'b0));
    send_item(mk_item(OP_SAMPLE, 0, 0, 0, 0, 0, 1'b0));
    send_item(mk_item(OP_SAMPLE, 0, 0, 0, 0, 8950, 1'b1));
  endtask

  task automatic test_extremes();
    drain_block();
    write_cfg(REG_TICKS_PER_INCH, 16'hFFFF);
    send_item(mk_item(OP_START, 1023, 1080, 127, 0, 0, 1'b0));
    send_item(mk_item(OP_SAMPLE, 0, 0, 0, -131072, -1048576, 1'b0));
    send_item(mk_item(OP_SAMPLE, 0, 0, 0, 131071, 1048575, 1'b1));
    send_item(mk_item(OP_START, -1024, -1080, 0, 0, 0, 1'b1));
    send_item(mk_item(OP_SAMPLE, 0, 0, 0, 131071, 1048575, 1'b1));
    send_item(mk_item(OP_SAMPLE, 0, 0, 0, -131072, -1048576, 1'b0));
  endtask

  task automatic test_timeout();
    drain_block();
    write_cfg(REG_DIST_TOL, 16'h0000);
    write_cfg(REG_TURN_TOL, 16'h0000);
    write_cfg(REG_TIMEOUT, 16'd1);
    send_item(mk_item(OP_START, 5, 3, 60, 0, 0, 1'b0));
    send_item(mk_item(OP_SAMPLE, 0, 0, 0, 7, 40, 1'b0));
    drain_block();
    write_cfg(REG_TIMEOUT, 16'd0);
    send_item(mk_item(OP_START, -5, -3, 60, 0, 0, 1'b0));
    send_item(mk_item(OP_SAMPLE, 0, 0, 0, -7, -40, 1'b1));
    drain_block();
    write_cfg(REG_TIMEOUT, 16'd3);
    send_item(mk_item(OP_START, 9, 1, 30, 0, 0, 1'b1));
    repeat (3) send_item(mk_item(OP_SAMPLE, 0, 0, 0, 1000, -500, 1'b0));
  endtask

  task automatic test_integral();
    drain_block();
    write_cfg(REG_TICKS_PER_INCH, 16'd256);
    write_cfg(REG_DIST_KI, 16'hFFFF);
    write_cfg(REG_DIST_KP, 16'h0000);
    write_cfg(REG_DIST_KD, 16'h0000);
    write_cfg(REG_TIMEOUT, 16'd1023);
    send_item(mk_item(OP_START, 20, 0, 127, 0, 0, 1'b0));
    send_item(mk_item(OP_SAMPLE, 0, 0, 0, 15, 0, 1'b0));
    send_item(mk_item(OP_SAMPLE, 0, 0, 0, 10, 0, 1'b0));
    // error beyond the inch count clears the sum
    send_item(mk_item(OP_SAMPLE, 0, 0, 0, -10, 0, 1'b0));
    send_item(mk_item(OP_SAMPLE, 0, 0, 0, 30, 0, 1'b1));
    // zero error clears it too
    send_item(mk_item(OP_SAMPLE, 0, 0, 0, 20, 500, 1'b0));
  endtask

  task automatic test_backpressure();
    drain_block();
    write_cfg(REG_DIST_TOL, 16'h0000);
    write_cfg(REG_TURN_TOL, 16'h0000);
    write_cfg(REG_TIMEOUT, 16'd1023);
    write_cfg(REG_DIST_KP, 16'd200);
    send_item(mk_item(OP_START, 50, 45, 100, 0, 0, 1'b0));
    rx_hold = 300;
    tx_no_gap = 1'b1;
    for (int k = 0; k < 16; k++) begin
      send_item(mk_item(OP_SAMPLE, 0, 0, 0, k * 300 - 2000, k * 100, k[0]));
    end
    tx_no_gap = 1'b0;
  endtask

  task automatic test_random();
    int next_cfg;
    next_cfg = work_items + 100;
    while (work_items < ITEM_TARGET) begin
      if (work_items >= next_cfg) begin
        drain_block();
        randomize_config();
        next_cfg = work_items + $urandom_range(60, 140);
      end
      random_move();
    end
  endtask

  // receiver: random stalls, free stretches, and a long hold on request
  initial begin : rx_proc
    int go_left;
    int stall_left;
    int r;
    go_left = 0;
    stall_left = 0;
    forever begin
      @(posedge clk);
      if (rx_hold > 0) begin
        stall_left = rx_hold;
        rx_hold = 0;
        go_left = 0;
      end
      if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else if (go_left > 0) begin
        go_left--;
        out_stall <= 1'b0;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 3) begin
          go_left = $urandom_range(50, 200);
        end else begin
          go_left = $urandom_range(0, 6);
          stall_left = (r < 97) ? $urandom_range(1, 3) : $urandom_range(20, 60);
        end
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin : result_check
    drive_cmd_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_cmds.size() == 0) begin
        $error("result with nothing expected: left %0d right %0d done %0d",
               out_left_drive, out_right_drive, out_move_done);
        n_errors++;
      end else begin
        want = pending_cmds.pop_front();
        if (out_left_drive !== want.left) begin
          $error("left_drive: expected %0d, actual %0d", want.left, out_left_drive);
          n_errors++;
        end
        if (out_right_drive !== want.right) begin
          $error("right_drive: expected %0d, actual %0d", want.right, out_right_drive);
          n_errors++;
        end
        if (out_catapult_drive !== want.cata) begin
          $error("catapult_drive: expected %0d, actual %0d", want.cata,
                 out_catapult_drive);
          n_errors++;
        end
        if (out_move_done !== want.done) begin
          $error("move_done: expected %0d, actual %0d", want.done, out_move_done);
          n_errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("tb: errors");
      $finish;
    end
  end

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_idle_and_turn();
    test_extremes();
    test_timeout();
    test_integral();
    test_backpressure();
    test_random();
    drain_block();
    if (n_errors == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule

// File: files.f
src/dpid_pkg.sv
src/drive_pid_with_heading_hold_core.sv
dv/tb.sv
